/* sv/tst_pkg.sv */
// ----------------------------------------------------------------------------
// tst_pkg
// Shared types, constants and byte tables of the template to script translator
// ----------------------------------------------------------------------------
`default_nettype none

package tst_pkg;

  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned QUEUE_DEPTH = 2;   // power of two, pointers wrap
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;
  localparam int unsigned STR_W       = 56;

  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_DQ   = 8'h22;
  localparam logic [7:0] CH_HASH = 8'h23;

  // fixed strings, right-justified, first byte highest
  localparam logic [STR_W-1:0] STR_PRINT  = "print \"";
  localparam logic [STR_W-1:0] STR_CLOSE  = "\"; ";
  localparam logic [STR_W-1:0] STR_NL     = "\\n\"\n";
  localparam logic [STR_W-1:0] STR_TAB    = "\\t";
  localparam logic [STR_W-1:0] STR_XOPEN  = "print((";
  localparam logic [STR_W-1:0] STR_XCLOSE = ")); ";
  localparam logic [STR_W-1:0] STR_SEMI   = "; ";
  localparam logic [STR_W-1:0] STR_QUOTE  = "\"";

  typedef enum logic [2:0] {
    REG_BF, REG_BS, REG_EF, REG_ES, REG_XM, REG_CM, REG_LM
  } reg_idx_t;

  typedef enum logic [3:0] {
    M_START, M_HEADER, M_TEXT, M_AFTER_BF, M_AFTER_BEGIN,
    M_SECTION, M_SECTION_EF, M_AFTER_LM, M_CODE_LINE
  } mode_t;

  typedef enum logic [1:0] {Q_LINE_START, Q_AFTER_SECTION, Q_IN_STRING} quote_t;
  typedef enum logic [1:0] {K_STMT, K_EXPR, K_COMMENT} kind_t;
  typedef enum logic [1:0] {ST_RUN, ST_OK, ST_NO_END} status_t;
  typedef enum logic [1:0] {PRE_NONE, PRE_PRINT, PRE_CLOSE} pre_t;
  typedef enum logic [2:0] {
    SUF_NONE, SUF_NL, SUF_TAB, SUF_XOPEN, SUF_XCLOSE, SUF_SEMI, SUF_QUOTE
  } suf_t;

  typedef struct packed {
    logic [7:0] bf;
    logic [7:0] bs;
    logic [7:0] ef;
    logic [7:0] es;
    logic [7:0] xm;
    logic [7:0] cm;
    logic [7:0] lm;
  } cfg_t;

  typedef struct packed {
    mode_t      mode;
    quote_t     quote;
    kind_t      kind;
    logic [1:0] cls;    // bit 0: last byte was end_first, bit 1: newline
  } pstate_t;

  // one request's output: prefix string, up to three bytes, suffix string
  typedef struct packed {
    status_t         status;
    pre_t            pre;
    logic [1:0]      mid_cnt;
    logic [2:0][7:0] mid;
    suf_t            suf;
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } qhead_t;

  function automatic logic [7:0] str_byte(logic [STR_W-1:0] s, logic [2:0] n,
                                          logic [2:0] i);
    logic [2:0] pos;
    pos = n - 3'd1 - i;
    return s[{pos, 3'b000} +: 8];
  endfunction

  function automatic logic [2:0] pre_len(pre_t p);
    logic [2:0] n;
    unique case (p)
      PRE_PRINT: n = 3'd7;
      PRE_CLOSE: n = 3'd3;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] suf_len(suf_t s);
    logic [2:0] n;
    unique case (s)
      SUF_NL:     n = 3'd4;
      SUF_TAB:    n = 3'd2;
      SUF_XOPEN:  n = 3'd7;
      SUF_XCLOSE: n = 3'd4;
      SUF_SEMI:   n = 3'd2;
      SUF_QUOTE:  n = 3'd1;
      default:    n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] pre_byte(pre_t p, logic [2:0] i);
    logic [7:0] b;
    unique case (p)
      PRE_PRINT: b = str_byte(STR_PRINT, pre_len(p), i);
      PRE_CLOSE: b = str_byte(STR_CLOSE, pre_len(p), i);
      default:   b = 8'd0;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] suf_byte(suf_t s, logic [2:0] i);
    logic [7:0] b;
    unique case (s)
      SUF_NL:     b = str_byte(STR_NL, suf_len(s), i);
      SUF_TAB:    b = str_byte(STR_TAB, suf_len(s), i);
      SUF_XOPEN:  b = str_byte(STR_XOPEN, suf_len(s), i);
      SUF_XCLOSE: b = str_byte(STR_XCLOSE, suf_len(s), i);
      SUF_SEMI:   b = str_byte(STR_SEMI, suf_len(s), i);
      SUF_QUOTE:  b = str_byte(STR_QUOTE, suf_len(s), i);
      default:    b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* sv/tst_front.sv */
// ----------------------------------------------------------------------------
// tst_front
// Parser front end: holds the delimiter registers and the parse state, and
// turns each accepted byte into an output descriptor for the queue
// ----------------------------------------------------------------------------
`default_nettype none

module tst_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  input  wire logic [7:0]                      in_char,
  input  wire logic                            in_end,
  output logic                                 in_ready,
  input  wire logic                            cfg_wr_en,
  input  wire logic [tst_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [7:0]                      cfg_wdata,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output tst_pkg::desc_t                       q_desc
);
  import tst_pkg::*;

  cfg_t    cfg_r;
  pstate_t state_r, state_nxt;
  logic    accept;
  desc_t   d;

  function automatic logic [1:0] class_of(logic [7:0] c, logic [7:0] ef);
    return {c == CH_LF, c == ef};
  endfunction

  function automatic pstate_t text_next(pstate_t s, logic [7:0] c, cfg_t g);
    pstate_t r;
    r = s;
    r.mode = M_TEXT;
    if (c == g.bf) begin
      r.mode = M_AFTER_BF;
    end else if (c == g.lm && s.quote == Q_LINE_START) begin
      r.mode = M_AFTER_LM;
    end else begin
      r.quote = (c == CH_LF) ? Q_LINE_START : Q_IN_STRING;
    end
    return r;
  endfunction

  function automatic pstate_t section_next(pstate_t s, logic [7:0] c, cfg_t g);
    pstate_t r;
    r = s;
    r.mode = M_SECTION;
    if (c == g.ef) begin
      r.mode = M_SECTION_EF;
    end else begin
      r.cls = class_of(c, g.ef);
    end
    return r;
  endfunction

  function automatic pstate_t code_next(pstate_t s, logic [7:0] c);
    pstate_t r;
    r = s;
    if (c == CH_LF) begin
      r.quote = Q_LINE_START;
      r.mode  = M_TEXT;
    end else begin
      r.mode = M_CODE_LINE;
    end
    return r;
  endfunction

  function automatic desc_t add_mid(desc_t x, logic [7:0] b);
    desc_t r;
    r = x;
    r.mid[r.mid_cnt] = b;
    r.mid_cnt = r.mid_cnt + 2'd1;
    return r;
  endfunction

  function automatic desc_t add_plain(desc_t x, logic [7:0] c);
    desc_t r;
    r = x;
    if (c == CH_LF) begin
      r.suf = SUF_NL;
    end else if (c == CH_TAB) begin
      r.suf = SUF_TAB;
    end else if (c == CH_BSL || c == CH_DQ || c == CH_HASH) begin
      r = add_mid(add_mid(r, CH_BSL), c);
    end else begin
      r = add_mid(r, c);
    end
    return r;
  endfunction

  function automatic pre_t open_pre(quote_t q);
    return (q != Q_IN_STRING) ? PRE_PRINT : PRE_NONE;
  endfunction

  function automatic desc_t text_out(desc_t x, pstate_t s, logic [7:0] c, cfg_t g);
    desc_t r;
    r = x;
    if (!(c == g.bf || (c == g.lm && s.quote == Q_LINE_START))) begin
      r.pre = open_pre(s.quote);
      r = add_plain(r, c);
    end
    return r;
  endfunction

  function automatic desc_t section_out(desc_t x, pstate_t s, logic [7:0] c,
                                        cfg_t g);
    desc_t r;
    r = x;
    if (c != g.ef && (c == CH_LF || s.kind != K_COMMENT)) begin
      r = add_mid(r, c);
    end
    return r;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  // delimiter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bf <= 8'd60;
      cfg_r.bs <= 8'd37;
      cfg_r.ef <= 8'd37;
      cfg_r.es <= 8'd62;
      cfg_r.xm <= 8'd61;
      cfg_r.cm <= 8'd35;
      cfg_r.lm <= 8'd37;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_BF:  cfg_r.bf <= cfg_wdata;
        REG_BS:  cfg_r.bs <= cfg_wdata;
        REG_EF:  cfg_r.ef <= cfg_wdata;
        REG_ES:  cfg_r.es <= cfg_wdata;
        REG_XM:  cfg_r.xm <= cfg_wdata;
        REG_CM:  cfg_r.cm <= cfg_wdata;
        REG_LM:  cfg_r.lm <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{mode: M_START, quote: Q_LINE_START, kind: K_STMT, cls: 2'b00};
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  // next parse state
  always_comb begin
    state_nxt = state_r;
    if (in_end) begin
      state_nxt = '{mode: M_START, quote: Q_LINE_START, kind: K_STMT, cls: 2'b00};
    end else begin
      unique case (state_r.mode)
        M_START: begin
          if (in_char == CH_HASH) state_nxt.mode = M_HEADER;
          else state_nxt = text_next(state_r, in_char, cfg_r);
        end
        M_HEADER: begin
          if (in_char == CH_LF) state_nxt.mode = M_TEXT;
        end
        M_AFTER_BF: begin
          if (in_char == cfg_r.bs) begin
            state_nxt.mode = M_AFTER_BEGIN;
          end else begin
            state_nxt.quote = Q_IN_STRING;
            state_nxt = text_next(state_nxt, in_char, cfg_r);
          end
        end
        M_AFTER_BEGIN: begin
          if (in_char == cfg_r.bs) begin
            state_nxt.quote = Q_IN_STRING;
            state_nxt.mode  = M_TEXT;
          end else begin
            state_nxt.cls  = 2'b00;
            state_nxt.mode = M_SECTION;
            if (in_char == cfg_r.cm) begin
              state_nxt.kind = K_COMMENT;
            end else if (in_char == cfg_r.xm) begin
              state_nxt.kind = K_EXPR;
            end else begin
              state_nxt.kind = K_STMT;
              state_nxt = section_next(state_nxt, in_char, cfg_r);
            end
          end
        end
        M_SECTION: state_nxt = section_next(state_r, in_char, cfg_r);
        M_SECTION_EF: begin
          if (in_char == cfg_r.es) begin
            if (state_r.cls[0]) begin
              state_nxt.cls  = class_of(cfg_r.es, cfg_r.ef);
              state_nxt.mode = M_SECTION;
            end else begin
              state_nxt.quote = Q_AFTER_SECTION;
              state_nxt.mode  = M_TEXT;
            end
          end else begin
            state_nxt.cls = class_of(cfg_r.ef, cfg_r.ef);
            state_nxt = section_next(state_nxt, in_char, cfg_r);
          end
        end
        M_AFTER_LM: begin
          if (in_char == cfg_r.lm) begin
            state_nxt.quote = Q_IN_STRING;
            state_nxt.mode  = M_TEXT;
          end else begin
            state_nxt = code_next(state_r, in_char);
          end
        end
        M_CODE_LINE: state_nxt = code_next(state_r, in_char);
        default:     state_nxt = text_next(state_r, in_char, cfg_r);
      endcase
    end
  end

  // output descriptor
  always_comb begin
    d = '0;
    if (in_end) begin
      d.status = ST_OK;
      unique case (state_r.mode) inside
        M_AFTER_BF: begin
          d.pre = open_pre(state_r.quote);
          d = add_mid(d, cfg_r.bf);
          d.suf = SUF_QUOTE;
        end
        M_AFTER_BEGIN, M_SECTION, M_SECTION_EF, M_AFTER_LM, M_CODE_LINE: begin
          d.status = ST_NO_END;
        end
        default: begin
          if (state_r.quote == Q_IN_STRING) d.suf = SUF_QUOTE;
        end
      endcase
    end else begin
      unique case (state_r.mode)
        M_START: begin
          if (in_char != CH_HASH) d = text_out(d, state_r, in_char, cfg_r);
        end
        M_HEADER: begin
          if (in_char == CH_LF) d = add_mid(d, CH_LF);
        end
        M_AFTER_BF: begin
          if (in_char != cfg_r.bs) begin
            d.pre = open_pre(state_r.quote);
            d = add_mid(d, cfg_r.bf);
            // string is open now, so only a fresh begin byte stays silent
            if (in_char != cfg_r.bf) d = add_plain(d, in_char);
          end
        end
        M_AFTER_BEGIN: begin
          if (in_char == cfg_r.bs) begin
            d.pre = open_pre(state_r.quote);
            d = add_mid(add_mid(d, cfg_r.bf), cfg_r.bs);
          end else begin
            d.pre = (state_r.quote == Q_IN_STRING) ? PRE_CLOSE : PRE_NONE;
            if (in_char == cfg_r.cm) begin
              d.suf = SUF_NONE;
            end else if (in_char == cfg_r.xm) begin
              d.suf = SUF_XOPEN;
            end else if (in_char != cfg_r.ef) begin
              d = add_mid(d, in_char);
            end
          end
        end
        M_SECTION: d = section_out(d, state_r, in_char, cfg_r);
        M_SECTION_EF: begin
          if (in_char == cfg_r.es) begin
            if (state_r.cls[0]) begin
              if (state_r.kind != K_COMMENT) d = add_mid(d, cfg_r.es);
            end else if (state_r.kind == K_EXPR) begin
              d.suf = SUF_XCLOSE;
            end else if (state_r.kind == K_STMT && !state_r.cls[1]) begin
              d.suf = SUF_SEMI;
            end
          end else begin
            if (state_r.kind != K_COMMENT) d = add_mid(d, cfg_r.ef);
            d = section_out(d, state_r, in_char, cfg_r);
          end
        end
        M_AFTER_LM: begin
          if (in_char == cfg_r.lm) d.pre = open_pre(state_r.quote);
          d = add_mid(d, in_char);
        end
        M_CODE_LINE: d = add_mid(d, in_char);
        default:     d = text_out(d, state_r, in_char, cfg_r);
      endcase
    end
  end

  // silent bytes leave nothing for the back end
  assign q_push = accept && (d.status != ST_RUN || d.pre != PRE_NONE ||
                             d.mid_cnt != 2'd0 || d.suf != SUF_NONE);
  assign q_desc = d;

endmodule

`default_nettype wire

/* sv/tst_queue.sv */
// ----------------------------------------------------------------------------
// tst_queue
// Two-entry descriptor queue between the parser and the byte emitter
// ----------------------------------------------------------------------------
`default_nettype none

module tst_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire tst_pkg::desc_t push_desc,
  input  wire logic           pop,
  output logic                full,
  output tst_pkg::qhead_t     head
);
  import tst_pkg::*;

  desc_t             entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_pop;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.desc  = entry_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push)   wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (push && !do_pop)      cnt_r <= cnt_r + QCNT_W'(1);
      else if (!push && do_pop) cnt_r <= cnt_r - QCNT_W'(1);
    end
  end

endmodule

`default_nettype wire

/* sv/tst_back.sv */
// ----------------------------------------------------------------------------
// tst_back
// Byte emitter: while out_ready does not stall it, walks the head descriptor one
// script byte per cycle into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module tst_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire tst_pkg::qhead_t head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           out_char,
  output logic                 out_char_valid,
  output logic                 out_last,
  output tst_pkg::status_t     out_status
);
  import tst_pkg::*;

  logic [3:0] idx_r;
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       out_char_valid_r;
  logic       out_last_r;
  status_t    out_status_r;

  logic [2:0] pl;
  logic [2:0] sl;
  logic [4:0] mid_end;
  logic [4:0] total;
  logic [4:0] idx_ext;
  logic [4:0] moff;
  logic [4:0] soff;
  logic [7:0] byte_sel;
  logic       is_null;
  logic       is_last;
  logic       load;

  assign pl      = pre_len(head.desc.pre);
  assign sl      = suf_len(head.desc.suf);
  assign mid_end = 5'(pl) + 5'(head.desc.mid_cnt);
  assign total   = mid_end + 5'(sl);
  assign idx_ext = 5'(idx_r);
  assign moff    = idx_ext - 5'(pl);
  assign soff    = idx_ext - mid_end;
  assign is_null = (total == 5'd0);
  assign is_last = is_null || (idx_ext + 5'd1 == total);
  assign load    = !out_valid_r || out_ready;
  assign q_pop   = load && head.valid && is_last;

  always_comb begin
    if (idx_ext < 5'(pl)) begin
      byte_sel = pre_byte(head.desc.pre, idx_r[2:0]);
    end else if (idx_ext < mid_end) begin
      byte_sel = head.desc.mid[moff[1:0]];
    end else begin
      byte_sel = suf_byte(head.desc.suf, soff[2:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= head.valid;
      if (head.valid) idx_r <= is_last ? 4'd0 : idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && head.valid) begin
      out_char_r       <= is_null ? 8'd0 : byte_sel;
      out_char_valid_r <= !is_null;
      out_last_r       <= is_last;
      out_status_r     <= head.desc.status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_char_valid = out_char_valid_r;
  assign out_last       = out_last_r;
  assign out_status     = out_status_r;

endmodule

`default_nettype wire

/* sv/template_to_script_translator.sv */
// ----------------------------------------------------------------------------
// template_to_script_translator
// Streams template bytes in and script bytes out
// ----------------------------------------------------------------------------
// Each input request is one template byte, or an end marker on tlast. The
// parser takes one request per cycle while its two-entry descriptor queue has
// room; a byte that emits nothing is not queued. The emitter sends one script
// byte per cycle while out_tready does not stall it; a request yields up to 12
// script bytes (an end marker with no bytes gives one empty result with tuser
// low). Plain text inside an open string gives one output byte per input byte;
// line starts, line ends, escapes and section delimiters give more. The end
// marker reports status and returns the parse state to its reset value;
// delimiter registers keep their values.
`default_nettype none

module template_to_script_translator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [7:0]                      in_tdata,   // [7:0] in_char
  input  wire logic                            in_tlast,   // end_of_input
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [15:0]                          out_tdata,  // [7:0] out_char, [9:8] status
  output logic                                 out_tuser,  // [0] char_valid
  output logic                                 out_tlast,  // last
  input  wire logic                            cfg_wr_en,
  input  wire logic [tst_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [7:0]                      cfg_wdata
);
  import tst_pkg::*;

  logic    q_push;
  logic    q_pop;
  logic    q_full;
  desc_t   q_desc;
  qhead_t  q_head;
  logic [7:0] o_char;
  status_t o_status;

  tst_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_char   (in_tdata),
    .in_end    (in_tlast),
    .in_ready  (in_tready),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_desc    (q_desc)
  );

  tst_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_desc),
    .pop       (q_pop),
    .full      (q_full),
    .head      (q_head)
  );

  tst_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_char       (o_char),
    .out_char_valid (out_tuser),
    .out_last       (out_tlast),
    .out_status     (o_status)
  );

  assign out_tdata = {6'd0, o_status, o_char};

endmodule

`default_nettype wire

/* sv/tst_checker.sv */
// ----------------------------------------------------------------------------
// tst_checker
// Port-level checks of the template to script translator
// ----------------------------------------------------------------------------
`default_nettype none

module tst_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tuser,
  input wire logic        out_tlast
);
  import tst_pkg::*;

  // a stalled result is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // an empty result only closes an end-of-input request
  a_null_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && out_tdata[9:8] != ST_RUN)
    else $error("empty result without final status");

  a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[7:0] == 8'd0 && out_tdata[15:10] == 6'd0)
    else $error("empty result carries data");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[9:8] != 2'd3)
    else $error("undefined status code");

  // a missing end delimiter gives no bytes
  a_no_end_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9:8] == ST_NO_END |-> !out_tuser && out_tlast)
    else $error("bytes emitted with missing end delimiter");

endmodule

bind template_to_script_translator tst_checker u_tst_checker (.*);

`default_nettype wire
